// ===== src/pfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfps_pkg;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SUM_W       = 29;
  localparam int unsigned PF_W        = 24;
  localparam int unsigned EN_W        = 28;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEFAULT_MAX_TRACE_SAMPLES = 4096;

  localparam logic [CFG_W-1:0] SHORT_WINDOW_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] LONG_WINDOW_RESET  = CFG_W'(256);

  typedef enum logic {
    REG_SHORT_WINDOW = 1'b0,
    REG_LONG_WINDOW  = 1'b1
  } cfg_reg_e;

  // charge sums and short-trace flag of one finished trace
  typedef struct packed {
    logic signed [SUM_W-1:0] short_sum;
    logic signed [SUM_W-1:0] long_sum;
    logic signed [SUM_W-1:0] total_sum;
    logic                    short_trace;
  } trace_rec_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]    acc,
    input logic signed [SAMPLE_W-1:0] smp
  );
    logic signed [SUM_W:0] wide;
    wide = {acc[SUM_W-1], acc} + {{(SUM_W+1-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat_add = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = wide[SUM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/pfps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfps_front #(
  parameter int unsigned MAX_TRACE_SAMPLES = pfps_pkg::DEFAULT_MAX_TRACE_SAMPLES
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [0:0]                       cfg_index_i,
  input  wire logic [pfps_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [pfps_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                             last_sample_i,
  input  wire logic                             q_full_i,
  output logic                                  push_o,
  output pfps_pkg::trace_rec_t                  push_rec_o
);
  import pfps_pkg::*;

  localparam int unsigned IW = $clog2(MAX_TRACE_SAMPLES + 1);
  localparam int unsigned CW = (IW > CFG_W) ? IW : CFG_W;

  logic [CFG_W-1:0]        short_window_q, long_window_q;
  logic [IW-1:0]           idx_q, idx_d;
  logic signed [SUM_W-1:0] short_q, short_d, long_q, long_d, total_q, total_d;
  logic                    in_range, accept;
  logic [CW-1:0]           idx_ext, len_ext, sw_ext, lw_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign in_range = idx_q < IW'(MAX_TRACE_SAMPLES);
  assign idx_ext  = CW'(idx_q);
  assign sw_ext   = CW'(short_window_q);
  assign lw_ext   = CW'(long_window_q);

  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    idx_d   = idx_q;
    if (in_range) begin
      if (idx_ext < sw_ext) short_d = sat_add(short_q, sample_i);
      if (idx_ext < lw_ext) long_d = sat_add(long_q, sample_i);
      idx_d = idx_q + 1'b1;
    end
    total_d = sat_add(total_q, sample_i);
  end

  assign len_ext                = CW'(idx_d);
  assign push_o                 = accept && last_sample_i;
  assign push_rec_o.short_sum   = short_d;
  assign push_rec_o.long_sum    = long_d;
  assign push_rec_o.total_sum   = total_d;
  assign push_rec_o.short_trace = (len_ext < sw_ext) || (len_ext < lw_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_window_q <= SHORT_WINDOW_RESET;
      long_window_q  <= LONG_WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SHORT_WINDOW: short_window_q <= cfg_data_i;
        REG_LONG_WINDOW:  long_window_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      short_q <= '0;
      long_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      if (last_sample_i) begin
        idx_q   <= '0;
        short_q <= '0;
        long_q  <= '0;
        total_q <= '0;
      end else begin
        idx_q   <= idx_d;
        short_q <= short_d;
        long_q  <= long_d;
        total_q <= total_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pfps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfps_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pfps_pkg::trace_rec_t push_rec_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output pfps_pkg::trace_rec_t      pop_rec_o,
  output logic                      empty_o
);
  import pfps_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  trace_rec_t    entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   count_q;

  assign full_o    = count_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o   = count_q == '0;
  assign pop_rec_o = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      priority if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i)     count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfps_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire pfps_pkg::trace_rec_t q_rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [pfps_pkg::PF_W-1:0] prompt_fraction_o,
  output logic signed [pfps_pkg::EN_W-1:0] event_energy_o,
  output logic                      zero_divisor_o,
  output logic                      short_trace_o
);
  import pfps_pkg::*;

  localparam int unsigned SH  = PF_W - FRAC_W;
  localparam int unsigned CNW = $clog2(PF_W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_OUT  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [SUM_W-1:0]        abs_n, abs_d;
  logic                    load_ovf;
  logic signed [SUM_W:0]   neg_total;
  logic [SUM_W-EN_W+1:0]   en_hi;
  logic [EN_W-1:0]         en_sat;

  logic [SUM_W-1:0]        rem_q, den_q;
  logic [PF_W-1:0]         lo_q;
  logic [CNW-1:0]          cnt_q;
  logic                    neg_q, ovf_q;
  logic [SUM_W:0]          trial;
  logic                    fits;
  logic [PF_W-1:0]         pf_fix;

  // operand magnitudes and the quotient range check
  assign abs_n = q_rec_i.short_sum[SUM_W-1] ? (~q_rec_i.short_sum + 1'b1) : q_rec_i.short_sum;
  assign abs_d = q_rec_i.long_sum[SUM_W-1] ? (~q_rec_i.long_sum + 1'b1) : q_rec_i.long_sum;
  assign load_ovf = {{SH{1'b0}}, abs_n} >= {abs_d, {SH{1'b0}}};

  // energy is the negated total, clamped
  assign neg_total = -{q_rec_i.total_sum[SUM_W-1], q_rec_i.total_sum};
  assign en_hi     = neg_total[SUM_W:EN_W-1];
  always_comb begin
    if (en_hi == '0 || en_hi == '1) begin
      en_sat = neg_total[EN_W-1:0];
    end else begin
      en_sat = neg_total[SUM_W] ? {1'b1, {(EN_W-1){1'b0}}} : {1'b0, {(EN_W-1){1'b1}}};
    end
  end

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, lo_q[PF_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    if (zero_divisor_o) begin
      pf_fix = '0;
    end else if (neg_q) begin
      if (ovf_q || lo_q > {1'b1, {(PF_W-1){1'b0}}}) pf_fix = {1'b1, {(PF_W-1){1'b0}}};
      else pf_fix = ~lo_q + 1'b1;
    end else begin
      if (ovf_q || lo_q[PF_W-1]) pf_fix = {1'b0, {(PF_W-1){1'b1}}};
      else pf_fix = lo_q;
    end
  end

  assign pop_o       = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = state_q == ST_OUT;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = (abs_d == '0 || load_ovf) ? ST_FIX : ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_FIX;
      ST_FIX:  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          rem_q          <= abs_n >> SH;
          lo_q           <= {abs_n[SH-1:0], {FRAC_W{1'b0}}};
          den_q          <= abs_d;
          cnt_q          <= CNW'(PF_W - 1);
          neg_q          <= q_rec_i.short_sum[SUM_W-1] != q_rec_i.long_sum[SUM_W-1];
          ovf_q          <= load_ovf;
          zero_divisor_o <= abs_d == '0;
          short_trace_o  <= q_rec_i.short_trace;
          event_energy_o <= en_sat;
        end
      end
      ST_DIV: begin
        rem_q <= fits ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
        lo_q  <= {lo_q[PF_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FIX:  prompt_fraction_o <= pf_fix;
      ST_OUT:  ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/prompt_fraction_pulse_shape.sv =====
// Charge-comparison pulse-shape discriminator. Samples of a trace enter one per clock while
// in_ready_o is high and are summed into short window, long window and whole-trace charge;
// the sample flagged as last closes the trace and its sums go into a two-entry queue. A back
// end divides short by long charge with a restoring divider that yields one quotient bit a
// cycle; it skips the divide when the long sum is zero or the quotient does not fit in 24
// bits, and holds each result until out_ready_i. Input keeps flowing at one sample a cycle
// while the queue has room; short traces back to back fill the queue and in_ready_o then
// drops until the divider frees an entry. Window registers are written via the cfg port;
// the user must write them only while no trace is in flight, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module prompt_fraction_pulse_shape #(
  parameter int unsigned MAX_TRACE_SAMPLES = pfps_pkg::DEFAULT_MAX_TRACE_SAMPLES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [0:0]                           cfg_index_i,
  input  wire logic [pfps_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [pfps_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 last_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [pfps_pkg::PF_W-1:0]          prompt_fraction_o,
  output logic signed [pfps_pkg::EN_W-1:0]          event_energy_o,
  output logic                                      zero_divisor_o,
  output logic                                      short_trace_o
);
  import pfps_pkg::*;

  logic       push, pop, q_full, q_empty;
  trace_rec_t push_rec, pop_rec;

  pfps_front #(
    .MAX_TRACE_SAMPLES(MAX_TRACE_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_rec_o   (push_rec)
  );

  pfps_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (q_full),
    .pop_i     (pop),
    .pop_rec_o (pop_rec),
    .empty_o   (q_empty)
  );

  pfps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_rec_i          (pop_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .prompt_fraction_o(prompt_fraction_o),
    .event_energy_o   (event_energy_o),
    .zero_divisor_o   (zero_divisor_o),
    .short_trace_o    (short_trace_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("trace record pushed into a full queue");

  a_closed_trace_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_sample_i |=> !q_empty)
    else $error("closed trace missing from the queue");

  a_zero_divisor_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> prompt_fraction_o == '0)
    else $error("non-zero fraction with zero long sum");

endmodule

`default_nettype wire
